>>> rtl/core/rcsa_pkg.sv
// Shared constants and types for the RGB contrast and saturation adjuster.
package rcsa_pkg;

   localparam int FB = 16;
   localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTRAST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SATURATION = 2'd2;

   localparam logic [15:0] DIV10_MUL = 16'd52429;
   localparam int DIV10_SH = 19;

   localparam int SAT_NW = 8 + FB;
   localparam int SAT_QW = 8 + FB;
   localparam int ALPHA_NW = 2 * FB + 1;
   localparam int ALPHA_DW = FB + 1;
   localparam int ALPHA_QW = FB + 9;
   localparam int INC_W = FB + 3;
   localparam int KW = 2 * FB - 7;
   localparam logic [KW-1:0] INC_K = KW'((64'd1 << (2 * FB)) / 200);

   localparam int ST_P4 = 3;
   localparam int ST_PA = ST_P4 + SAT_QW + 1;
   localparam int ST_PM = ST_PA + ALPHA_QW + 1;
   localparam int NST = ST_PM + 3;
   localparam int SB_LEN = ST_PM - ST_P4;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [8:0] sum;
      logic       grey;
   } sb_type;

endpackage

>>> rtl/core/rcsa_div.sv
// Pipelined restoring divider that resolves one quotient bit per register stage.
module rcsa_div #(
   parameter int NW = 24,
   parameter int DW = 8,
   parameter int QW = 24
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   logic [DW-1:0]    rem_ff [QW];
   logic [QW-1:0]    low_ff [QW];
   logic [QW-1:0]    quo_ff [QW];
   logic [DW-1:0]    den_ff [QW];
   logic [DW+NW-1:0] wide;

   assign wide = {{DW{1'b0}}, num};

   for (genvar s = 0; s < QW; s++) begin : g_step
      logic [DW-1:0] r_src;
      logic [QW-1:0] l_src;
      logic [QW-1:0] q_src;
      logic [DW-1:0] d_src;
      logic [DW:0]   t;
      logic          ge;

      if (s == 0) begin : g_first
         assign r_src = wide[QW +: DW];
         assign l_src = wide[QW-1:0];
         assign q_src = '0;
         assign d_src = den;
      end else begin : g_next
         assign r_src = rem_ff[s-1];
         assign l_src = low_ff[s-1];
         assign q_src = quo_ff[s-1];
         assign d_src = den_ff[s-1];
      end

      assign t  = {r_src, l_src[QW-1]};
      assign ge = t >= {1'b0, d_src};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? DW'(t - {1'b0, d_src}) : t[DW-1:0];
            low_ff[s] <= l_src << 1;
            quo_ff[s] <= {q_src[QW-2:0], ge};
            den_ff[s] <= d_src;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

>>> rtl/core/rgb_contrast_saturation_adjust_core.sv
// Top level of the RGB contrast, brightness and saturation adjuster.
//
// Pixels enter on the req_ channel and leave on the rsp_ channel, both
// valid/ready. Each transaction carries one 8-bit red, green and blue value
// and produces exactly one adjusted pixel, in order.
// The pipeline has 57 register stages. One pixel per cycle is taken and
// delivered in steady state when the receiver never stalls; the depth is
// set by the two pipelined dividers, one quotient bit per stage (24 for
// saturation, 25 for alpha). When rsp_ready is low while a result waits,
// the whole pipeline holds and req_ready drops; nothing is lost or
// repeated. Empty stages hold as well. The csr_ channel writes the contrast,
// brightness and saturation registers and is always ready. The user must
// make writes only while no pixel is in flight; the block does not check it.
// Synchronous reset empties the pipeline and sets those registers to one.
module rgb_contrast_saturation_adjust_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_red_in,
   input  logic [7:0]                     req_green_in,
   input  logic [7:0]                     req_blue_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_red_out,
   output logic [7:0]                     rsp_green_out,
   output logic [7:0]                     rsp_blue_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rcsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [8:0]                     csr_wdata
);
   import rcsa_pkg::*;

   logic              adv;
   logic [NST-1:0]    vld_ff;

   logic [7:0]        ctr_ff;
   logic signed [8:0] bri_ff;
   logic [8:0]        lvl_ff;

   logic signed [9:0]      lv_s;
   logic [8:0]             lv_mag;
   logic [8+KW:0]          incp_ff;
   logic [8:0]             incm_ff;
   logic                   incs_ff;
   logic [FB+1:0]          inc_q0;
   logic [FB+8:0]          inc_r;
   logic [FB+1:0]          inc_q;
   logic signed [INC_W-1:0] inc_ff;
   logic                   neg;

   logic [7:0]  pix [3];
   logic [15:0] prod_ff [3];
   logic [12:0] div10_ff [3];
   logic [7:0]  c1_ff [3];

   logic [7:0]   mx, mn;
   logic [8:0]   sum;
   sb_type       sb_in;
   sb_type       sbd_ff [SB_LEN];
   logic [7:0]   diff_ff;
   logic [7:0]   den_ff;

   logic [SAT_QW-1:0]   sat_q;
   logic signed [SAT_QW+1:0] sat_t;
   logic [ALPHA_DW-1:0] a_ff;
   logic [ALPHA_QW-1:0] alpha_q;
   logic [ALPHA_QW-1:0] alpha;
   logic [ALPHA_QW-1:0] m_val;
   logic [FB:0]         g_val;
   logic [FB:0]         oma;

   logic signed [9:0]   d2_ff [3];
   logic [ALPHA_QW-1:0] m_ff;
   logic [FB+7:0]       base_ff [3];
   sb_type              sbm_ff;
   logic signed [ALPHA_QW+10:0] p_ff [3];
   logic [FB+7:0]       basep_ff [3];
   sb_type              sbp_ff;

   logic [7:0] out_ff [3];

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];

   assign pix[0] = req_red_in;
   assign pix[1] = req_green_in;
   assign pix[2] = req_blue_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ctr_ff <= 8'd1;
         bri_ff <= 9'sd1;
         lvl_ff <= 9'd1;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[NST-2:0], req_valid};
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CONTRAST:   ctr_ff <= csr_wdata[7:0];
               CSR_BRIGHTNESS: bri_ff <= $signed(csr_wdata);
               CSR_SATURATION: lvl_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // The saturation increment follows the level register through incp_ff, incm_ff and incs_ff, then inc_ff.
   assign lv_s   = $signed({1'b0, lvl_ff}) - 10'sd80;
   assign lv_mag = lv_s[9] ? 9'(-lv_s) : lv_s[8:0];
   assign inc_q0 = incp_ff[FB +: FB+2];
   assign inc_r  = {incm_ff, {FB{1'b0}}} - (FB+9)'(inc_q0 * 8'd200);
   assign inc_q  = (inc_r >= (FB+9)'(200)) ? inc_q0 + 1'b1 : inc_q0;

   always_ff @(posedge clock) begin
      incp_ff <= lv_mag * INC_K;
      incm_ff <= lv_mag;
      incs_ff <= lv_s[9];
      inc_ff  <= incs_ff ? -$signed({1'b0, inc_q}) : $signed({1'b0, inc_q});
   end

   assign neg = inc_ff < 0;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ch = 0; ch < 3; ch++) begin
            logic [31:0]        sc;
            logic signed [14:0] s;
            prod_ff[ch]  <= ctr_ff * pix[ch];
            sc            = prod_ff[ch] * DIV10_MUL;
            div10_ff[ch] <= sc[DIV10_SH +: 13];
            s             = $signed({2'b0, div10_ff[ch]}) + 15'(bri_ff);
            if (s < 0) begin
               c1_ff[ch] <= 8'd0;
            end else if (s > 15'sd255) begin
               c1_ff[ch] <= 8'd255;
            end else begin
               c1_ff[ch] <= s[7:0];
            end
         end
      end
   end

   always_comb begin
      mx = c1_ff[0];
      mn = c1_ff[0];
      for (int ch = 1; ch < 3; ch++) begin
         if (c1_ff[ch] > mx) mx = c1_ff[ch];
         if (c1_ff[ch] < mn) mn = c1_ff[ch];
      end
      sum         = {1'b0, mx} + {1'b0, mn};
      sb_in.red   = c1_ff[0];
      sb_in.green = c1_ff[1];
      sb_in.blue  = c1_ff[2];
      sb_in.sum   = sum;
      sb_in.grey  = mx == mn;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sbd_ff[0] <= sb_in;
         for (int k = 1; k < SB_LEN; k++) begin
            sbd_ff[k] <= sbd_ff[k-1];
         end
         diff_ff <= mx - mn;
         den_ff  <= (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
      end
   end

   rcsa_div #(
      .NW(SAT_NW),
      .DW(8),
      .QW(SAT_QW)
   ) u_sat_div (
      .clock(clock),
      .en   (adv),
      .num  ({diff_ff, {FB{1'b0}}}),
      .den  (den_ff),
      .quo  (sat_q)
   );

   assign sat_t = $signed({2'b0, sat_q}) + (SAT_QW+2)'(inc_ff);
   assign oma   = ONE - (FB+1)'(inc_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= (sat_t >= $signed((SAT_QW+2)'(ONE))) ? sat_q[FB:0] : oma;
      end
   end

   rcsa_div #(
      .NW(ALPHA_NW),
      .DW(ALPHA_DW),
      .QW(ALPHA_QW)
   ) u_alpha_div (
      .clock(clock),
      .en   (adv),
      .num  (ALPHA_NW'(1) << (2 * FB)),
      .den  (a_ff),
      .quo  (alpha_q)
   );

   assign alpha = alpha_q - ALPHA_QW'(ONE);
   assign g_val = ONE + (FB+1)'(inc_ff);
   assign m_val = neg ? ALPHA_QW'(g_val) : alpha;

   always_ff @(posedge clock) begin
      if (adv) begin
         logic [7:0] cc [3];
         sb_type     sb;
         sb    = sbd_ff[SB_LEN-1];
         cc[0] = sb.red;
         cc[1] = sb.green;
         cc[2] = sb.blue;
         m_ff   <= m_val;
         sbm_ff <= sb;
         for (int ch = 0; ch < 3; ch++) begin
            d2_ff[ch]   <= $signed({1'b0, cc[ch], 1'b0}) - $signed({1'b0, sb.sum});
            base_ff[ch] <= neg ? (FB+8)'({sb.sum, {(FB-1){1'b0}}})
                               : (FB+8)'({cc[ch], {FB{1'b0}}});
         end
         sbp_ff <= sbm_ff;
         for (int ch = 0; ch < 3; ch++) begin
            p_ff[ch]     <= d2_ff[ch] * $signed({1'b0, m_ff});
            basep_ff[ch] <= base_ff[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         logic [7:0]                  cg [3];
         logic signed [ALPHA_QW+10:0] h;
         logic signed [ALPHA_QW+11:0] v;
         cg[0] = sbp_ff.red;
         cg[1] = sbp_ff.green;
         cg[2] = sbp_ff.blue;
         for (int ch = 0; ch < 3; ch++) begin
            h = (p_ff[ch] + $signed({{(ALPHA_QW+10){1'b0}}, p_ff[ch][ALPHA_QW+10]})) >>> 1;
            v = $signed({{(ALPHA_QW+12-(FB+8)){1'b0}}, basep_ff[ch]})
                + (ALPHA_QW+12)'(h);
            if (sbp_ff.grey) begin
               out_ff[ch] <= cg[ch];
            end else if (v < 0) begin
               out_ff[ch] <= 8'd0;
            end else if (v[ALPHA_QW+11:FB] > (ALPHA_QW+12-FB)'(255)) begin
               out_ff[ch] <= 8'd255;
            end else begin
               out_ff[ch] <= v[FB +: 8];
            end
         end
      end
   end

endmodule
